### src/command_frame_recognizer_top_assert.svh
// Assertion macros for the command frame recogniser top level.
// Needs a clock and a synchronous reset signal passed in by the user.
`ifndef COMMAND_FRAME_RECOGNIZER_TOP_ASSERT_SVH
`define COMMAND_FRAME_RECOGNIZER_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define CFR_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define CFR_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");

`endif

### src/cfr_pkg.sv
// Shared types, frame patterns and helpers for the command frame recogniser.
// No dependencies.
package cfr_pkg;

  localparam int WINDOW_BYTES_DEF = 20;

  localparam int SHORT_LEN = 7;
  localparam int PARAM_LEN = 20;
  localparam int CAL_LEN   = 14;
  localparam int HEAD_LEN  = 5;

  // Frame kind codes
  localparam logic [1:0] KIND_HANDSHAKE = 2'd0;
  localparam logic [1:0] KIND_REQUEST   = 2'd1;
  localparam logic [1:0] KIND_PARAM     = 2'd2;
  localparam logic [1:0] KIND_CAL       = 2'd3;

  // Last payload index of each long frame
  localparam logic [3:0] PARAM_LAST_IDX = 4'd13;
  localparam logic [3:0] CAL_LAST_IDX   = 4'd7;

  // Baud code positions in the parameter payload
  localparam logic [3:0] IDX_RS485_BAUD = 4'd6;
  localparam logic [3:0] IDX_RS232_BAUD = 4'd7;
  localparam logic [3:0] IDX_CAN_BAUD   = 4'd8;
  localparam logic [7:0] BAUD_CODE_MAX  = 8'd3;
  localparam logic [7:0] SERIAL_BAUD_DEF = 8'd0;
  localparam logic [7:0] CAN_BAUD_DEF    = 8'd1;

  localparam logic [7:0] FRAME_TAIL = 8'hAC;

  localparam logic [7:0] HS_FRAME [SHORT_LEN] =
    '{8'hAA, 8'h55, 8'h04, 8'h00, 8'h00, 8'h01, 8'hAB};
  localparam logic [7:0] RQ_FRAME [SHORT_LEN] =
    '{8'h52, 8'h4D, 8'h67, 8'h73, 8'h77, 8'h5E, 8'h69};
  localparam logic [7:0] PAR_HEAD [HEAD_LEN] =
    '{8'hAA, 8'h54, 8'h11, 8'h00, 8'h00};
  localparam logic [7:0] CAL_HEAD [HEAD_LEN] =
    '{8'hAA, 8'h51, 8'h0B, 8'h00, 8'h00};

  // Commands from controller to datapath
  typedef struct packed {
    logic shift;    // take the received byte into the window
    logic load;     // latch the match and first payload byte, clear the count
    logic advance;  // step to the next payload byte
  } cfr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic match;    // window ends in a recognised frame
    logic last;     // current result is the final one of the run
  } cfr_status_t;

  // Clamp out-of-range baud codes in parameter frames
  function automatic logic [7:0] clamp_baud(input logic [1:0] kind,
                                            input logic [3:0] idx,
                                            input logic [7:0] val);
    logic [7:0] res;
    res = val;
    if (kind == KIND_PARAM && val > BAUD_CODE_MAX) begin
      if (idx == IDX_RS485_BAUD || idx == IDX_RS232_BAUD) begin
        res = SERIAL_BAUD_DEF;
      end else if (idx == IDX_CAN_BAUD) begin
        res = CAN_BAUD_DEF;
      end
    end
    return res;
  endfunction

endpackage

### src/cfr_datapath.sv
// Datapath of the command frame recogniser: byte window, held count,
// frame matching and result registers. Depends on cfr_pkg.
module cfr_datapath import cfr_pkg::*; #(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  cfr_cmd_t    cmd,
  output cfr_status_t status,
  output logic [1:0]  frame_kind,
  output logic        has_payload,
  output logic [3:0]  payload_index,
  output logic [7:0]  payload_byte,
  output logic        last
);

  localparam int IDX_W = $clog2(WINDOW_BYTES);
  localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
  localparam int SHORT_START = WINDOW_BYTES - SHORT_LEN;
  localparam int PAR_START   = WINDOW_BYTES - PARAM_LEN;
  localparam int CAL_START   = WINDOW_BYTES - CAL_LEN;
  localparam int PAR_BASE    = PAR_START + HEAD_LEN;
  localparam int CAL_BASE    = CAL_START + HEAD_LEN;

  logic [7:0]       window [WINDOW_BYTES];
  logic [CNT_W-1:0] held_count;
  logic [1:0]       kind;
  logic [3:0]       idx;
  logic [7:0]       byte_q;

  logic             hs_ok, rq_ok, par_ok, cal_ok;
  logic [1:0]       match_kind;
  logic [1:0]       rd_kind;
  logic [3:0]       rd_idx;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_byte;

  // Shift the received byte in, newest at the top
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
        window[k] <= window[k+1];
      end
      window[WINDOW_BYTES-1] <= rx_byte;
    end
  end

  // Count held bytes, saturate at the window size, clear on a match
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (cmd.load) begin
      held_count <= '0;
    end else if (cmd.shift && held_count < CNT_W'(WINDOW_BYTES)) begin
      held_count <= held_count + CNT_W'(1);
    end
  end

  // Compare the window tail against each frame
  always_comb begin
    hs_ok  = held_count >= CNT_W'(SHORT_LEN);
    rq_ok  = held_count >= CNT_W'(SHORT_LEN);
    par_ok = held_count >= CNT_W'(PARAM_LEN) &&
             window[WINDOW_BYTES-1] == FRAME_TAIL;
    cal_ok = held_count >= CNT_W'(CAL_LEN) &&
             window[WINDOW_BYTES-1] == FRAME_TAIL;
    for (int i = 0; i < SHORT_LEN; i++) begin
      if (window[SHORT_START+i] != HS_FRAME[i]) hs_ok = 1'b0;
      if (window[SHORT_START+i] != RQ_FRAME[i]) rq_ok = 1'b0;
    end
    for (int i = 0; i < HEAD_LEN; i++) begin
      if (window[PAR_START+i] != PAR_HEAD[i]) par_ok = 1'b0;
      if (window[CAL_START+i] != CAL_HEAD[i]) cal_ok = 1'b0;
    end
  end

  // Pick the first match by priority
  always_comb begin
    if (hs_ok) begin
      match_kind = KIND_HANDSHAKE;
    end else if (rq_ok) begin
      match_kind = KIND_REQUEST;
    end else if (par_ok) begin
      match_kind = KIND_PARAM;
    end else begin
      match_kind = KIND_CAL;
    end
  end

  // Select the payload byte to load next
  always_comb begin
    rd_kind = cmd.load ? match_kind : kind;
    rd_idx  = cmd.load ? 4'd0 : idx + 4'd1;
    rd_addr = (rd_kind == KIND_PARAM) ? IDX_W'(PAR_BASE) : IDX_W'(CAL_BASE);
    rd_addr = rd_addr + IDX_W'(rd_idx);
    rd_byte = clamp_baud(rd_kind, rd_idx, window[rd_addr]);
  end

  // Hold the current result
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.advance) begin
      kind   <= rd_kind;
      idx    <= rd_idx;
      byte_q <= rd_byte;
    end
  end

  always_comb begin
    status.match = hs_ok || rq_ok || par_ok || cal_ok;
    status.last  = !kind[1] ||
                   (kind == KIND_PARAM && idx == PARAM_LAST_IDX) ||
                   (kind == KIND_CAL && idx == CAL_LAST_IDX);
  end

  assign frame_kind    = kind;
  assign has_payload   = kind[1];
  assign payload_index = kind[1] ? idx : 4'd0;
  assign payload_byte  = kind[1] ? byte_q : 8'd0;
  assign last          = status.last;

endmodule

### src/cfr_controller.sv
// Controller of the command frame recogniser: sequences byte intake,
// the match check and result delivery. Depends on cfr_pkg.
module cfr_controller import cfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  cfr_status_t status,
  output cfr_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0] state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

  // Decide the next state and the datapath commands
  always_comb begin
    state_next  = state;
    cmd.shift   = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.shift  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.match) begin
          cmd.load   = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          if (status.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/command_frame_recognizer_top.sv
// Top level of the command frame recogniser: controller plus datapath.
// Depends on cfr_pkg, cfr_controller, cfr_datapath and the assertion header.
//
// Takes one received serial byte per input transfer and watches the last
// WINDOW_BYTES bytes for handshake, data request, parameter set and
// calibration frames, in that priority. A byte that completes no frame passes
// through intake and then the match check. A matching short frame gives one
// result; a parameter frame gives 14 and a calibration frame 8, one per
// output transfer. The controller handles one byte at a time: input ready
// is low from the intake of a byte until its last result has been
// transferred.
`include "command_frame_recognizer_top_assert.svh"
module command_frame_recognizer_top import cfr_pkg::*; #(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] frame_kind,
  output logic       has_payload,
  output logic [3:0] payload_index,
  output logic [7:0] payload_byte,
  output logic       last
);

  cfr_cmd_t    cmd;
  cfr_status_t status;

  cfr_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cfr_datapath #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (rx_byte),
    .cmd           (cmd),
    .status        (status),
    .frame_kind    (frame_kind),
    .has_payload   (has_payload),
    .payload_index (payload_index),
    .payload_byte  (payload_byte),
    .last          (last)
  );

  // Intake and delivery never overlap
  `CFR_ASSERT_SAME(a_no_overlap, clk, rst, in_ready, !out_valid)
  // The check cycle after an intake shows no result
  `CFR_ASSERT_NEXT(a_check_gap, clk, rst, in_valid && in_ready, !out_valid)
  // The final result returns the block to intake
  `CFR_ASSERT_NEXT(a_last_frees, clk, rst, out_valid && out_ready && last, in_ready)
  // Payload positions stay inside the parameter frame payload
  `CFR_ASSERT_SAME(a_idx_range, clk, rst, out_valid && has_payload,
                   payload_index <= PARAM_LAST_IDX)

endmodule

### tb/tb.sv
// Self-checking testbench for command_frame_recognizer_top.
// Depends on cfr_pkg and the recogniser RTL; predicts every result from its own
// window model and checks each output transfer against the oldest expectation.
`timescale 1ns / 100ps

module tb;
  import cfr_pkg::*;

  localparam int WIN          = WINDOW_BYTES_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_BYTES = 260;

  typedef struct packed {
    logic [1:0] kind;
    logic       has_payload;
    logic [3:0] index;
    logic [7:0] value;
    logic       last;
  } frame_result_t;

  typedef enum int {
    SHAPE_PLAIN,
    SHAPE_NESTED_CAL,
    SHAPE_HIDDEN_HS,
    SHAPE_FLIPPED,
    SHAPE_CUT
  } frame_shape_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] frame_kind;
  logic       has_payload;
  logic [3:0] payload_index;
  logic [7:0] payload_byte;
  logic       last;

  // Predictor state
  logic [7:0]    rx_window [WIN];
  int            held_bytes = 0;
  frame_result_t expected_results [$];

  logic [7:0] tx_bytes [$];
  int         bytes_total = 0;
  int         bytes_taken = 0;
  int         idle_left = 0;
  int         stall_left = 0;
  int         fault_count = 0;
  int         cycle_no = 0;
  logic       steady = 1'b0;

  command_frame_recognizer_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_kind   (frame_kind),
    .has_payload  (has_payload),
    .payload_index(payload_index),
    .payload_byte (payload_byte),
    .last         (last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int frame_len(logic [1:0] kind);
    case (kind)
      KIND_PARAM: return PARAM_LEN;
      KIND_CAL:   return CAL_LEN;
      default:    return SHORT_LEN;
    endcase
  endfunction

  function automatic logic [7:0] pattern_byte(logic [1:0] kind, int pos);
    case (kind)
      KIND_HANDSHAKE: return HS_FRAME[pos];
      KIND_REQUEST:   return RQ_FRAME[pos];
      KIND_PARAM:     return PAR_HEAD[pos];
      default:        return CAL_HEAD[pos];
    endcase
  endfunction

  // True when the held bytes end in a complete frame of this kind
  function automatic bit window_ends_in(logic [1:0] kind);
    int len, n, i;
    len = frame_len(kind);
    n = (len == SHORT_LEN) ? len : HEAD_LEN;
    if (held_bytes < len) return 1'b0;
    for (i = 0; i < n; i++) begin
      if (rx_window[WIN - len + i] !== pattern_byte(kind, i)) return 1'b0;
    end
    if (len != SHORT_LEN && rx_window[WIN - 1] !== FRAME_TAIL) return 1'b0;
    return 1'b1;
  endfunction

  // Shift one byte into the window and queue the results it completes
  task automatic absorb_byte(input logic [7:0] b);
    frame_result_t r;
    logic [7:0]    v;
    int            i, k, len, n;
    for (i = 0; i < WIN - 1; i++) rx_window[i] = rx_window[i + 1];
    rx_window[WIN - 1] = b;
    if (held_bytes < WIN) held_bytes++;
    for (k = 0; k < 4; k++) begin
      if (window_ends_in(2'(k))) begin
        len = frame_len(2'(k));
        r.kind = 2'(k);
        if (len == SHORT_LEN) begin
          r.has_payload = 1'b0;
          r.index       = '0;
          r.value       = '0;
          r.last        = 1'b1;
          expected_results.push_back(r);
        end else begin
          n = len - HEAD_LEN - 1;
          for (i = 0; i < n; i++) begin
            v = rx_window[WIN - len + HEAD_LEN + i];
            // clamp out-of-range baud codes in parameter frames
            if (r.kind == KIND_PARAM && v > BAUD_CODE_MAX) begin
              if (i == IDX_RS485_BAUD || i == IDX_RS232_BAUD) begin
                v = SERIAL_BAUD_DEF;
              end else if (i == IDX_CAN_BAUD) begin
                v = CAN_BAUD_DEF;
              end
            end
            r.has_payload = 1'b1;
            r.index       = 4'(i);
            r.value       = v;
            r.last        = (i == n - 1);
            expected_results.push_back(r);
          end
        end
        held_bytes = 0;
        break;
      end
    end
  endtask

  // Mostly short gaps, a few long ones, none during steady stretches
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] payload_filler(logic [1:0] kind, int idx);
    if (kind == KIND_PARAM &&
        (idx == IDX_RS485_BAUD || idx == IDX_RS232_BAUD || idx == IDX_CAN_BAUD)) begin
      // bias baud codes around the clamp boundary
      case ($urandom_range(0, 3))
        0:       return 8'($urandom_range(0, 3));
        1:       return 8'd4;
        2:       return 8'hFF;
        default: return 8'($urandom);
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 8'h00;
        1:       return 8'hFF;
        2:       return HS_FRAME[0];
        default: return FRAME_TAIL;
      endcase
    end
    return 8'($urandom);
  endfunction

  task automatic queue_frame(input logic [1:0] kind, input frame_shape_t shape);
    logic [7:0] f [PARAM_LEN];
    int         len, i, p;
    len = frame_len(kind);
    for (i = 0; i < len; i++) begin
      if (len == SHORT_LEN || i < HEAD_LEN) begin
        f[i] = pattern_byte(kind, i);
      end else if (i == len - 1) begin
        f[i] = FRAME_TAIL;
      end else begin
        f[i] = payload_filler(kind, i - HEAD_LEN);
      end
    end
    case (shape)
      // parameter frame whose last 14 bytes also form a calibration frame
      SHAPE_NESTED_CAL: begin
        if (kind == KIND_PARAM) begin
          for (i = 0; i < HEAD_LEN; i++) f[HEAD_LEN + 1 + i] = CAL_HEAD[i];
        end
      end
      // calibration frame whose payload holds a handshake that consumes the head
      SHAPE_HIDDEN_HS: begin
        if (kind == KIND_CAL) begin
          for (i = 0; i < SHORT_LEN; i++) f[HEAD_LEN + i] = HS_FRAME[i];
        end
      end
      SHAPE_FLIPPED: begin
        p = $urandom_range(0, len - 1);
        f[p] = f[p] ^ (8'h01 << $urandom_range(0, 7));
      end
      SHAPE_CUT: len = $urandom_range(1, len - 1);
      default: ;
    endcase
    for (i = 0; i < len; i++) tx_bytes.push_back(f[i]);
  endtask

  task automatic queue_noise(input int n);
    int i;
    for (i = 0; i < n; i++) tx_bytes.push_back(8'($urandom));
  endtask

  // Toggle steady stretches now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) begin
      steady <= ~steady;
    end
  end

  // Input driver: hold each byte until its transfer, then pause at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_byte(rx_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte  <= tx_bytes.pop_front();
          idle_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each result transfer, stall at random
  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("unexpected result at cycle %0d: kind %0d index %0d byte %02h",
                     cycle_no, frame_kind, payload_index, payload_byte);
          end
        end else begin
          want = expected_results.pop_front();
          if (want.kind !== frame_kind || want.has_payload !== has_payload ||
              want.index !== payload_index || want.value !== payload_byte ||
              want.last !== last) begin
            fault_count++;
            if (fault_count <= 10) begin
              $write("mismatch at cycle %0d (expected/actual): kind %0d/%0d ",
                     cycle_no, want.kind, frame_kind);
              $display("has_payload %0d/%0d index %0d/%0d byte %02h/%02h last %0d/%0d",
                       want.has_payload, has_payload, want.index, payload_index,
                       want.value, payload_byte, want.last, last);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int pick;
    // Directed: byte extremes, a handshake after a false start, a data request
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(HS_FRAME[0]);
    tx_bytes.push_back(HS_FRAME[1]);
    queue_frame(KIND_HANDSHAKE, SHAPE_PLAIN);
    queue_frame(KIND_REQUEST, SHAPE_PLAIN);

    // Random: mostly well-formed frames with random payloads, some noise
    while (tx_bytes.size() < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        queue_frame(KIND_HANDSHAKE, SHAPE_PLAIN);
      end else if (pick < 22) begin
        queue_frame(KIND_REQUEST, SHAPE_PLAIN);
      end else if (pick < 42) begin
        queue_frame(KIND_PARAM, SHAPE_PLAIN);
      end else if (pick < 57) begin
        queue_frame(KIND_CAL, SHAPE_PLAIN);
      end else if (pick < 63) begin
        queue_frame(KIND_PARAM, SHAPE_NESTED_CAL);
      end else if (pick < 68) begin
        queue_frame(KIND_CAL, SHAPE_HIDDEN_HS);
      end else if (pick < 80) begin
        queue_frame(2'($urandom_range(0, 3)), SHAPE_FLIPPED);
      end else if (pick < 86) begin
        queue_frame(2'($urandom_range(0, 3)), SHAPE_CUT);
      end else if ($urandom_range(0, 4) == 0) begin
        // long run fills the window so the count saturates
        queue_noise($urandom_range(20, 30));
      end else begin
        queue_noise($urandom_range(1, 6));
      end
    end
    bytes_total = tx_bytes.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Drain: every byte taken and every expected result seen
    while (bytes_taken != bytes_total || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/cfr_pkg.sv
src/cfr_datapath.sv
src/cfr_controller.sv
src/command_frame_recognizer_top.sv
tb/tb.sv
